@@ rtl/core/bpd_pkg.sv @@
package bpd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOOK,
      ST_SCAN,
      ST_MUL,
      ST_BLEND,
      ST_EMIT
   } state_type;

   localparam logic [1:0] FUNC_PALETTE = 2'd0;
   localparam logic [1:0] FUNC_DATA    = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   localparam logic [2:0] REG_BPP        = 3'd0;
   localparam logic [2:0] REG_WIDTH      = 3'd1;
   localparam logic [2:0] REG_HEIGHT     = 3'd2;
   localparam logic [2:0] REG_MASK_RED   = 3'd3;
   localparam logic [2:0] REG_MASK_GREEN = 3'd4;
   localparam logic [2:0] REG_MASK_BLUE  = 3'd5;
   localparam logic [2:0] REG_MASK_ALPHA = 3'd6;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_ALPHA = 3;
   localparam int NUM_CH   = 4;

   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int MASK_W  = 32;

   // 8-bit truncated 255/(2^bits-1), zero for empty or wide masks
   function automatic logic [7:0] scale_of(input logic [5:0] bits);
      logic [7:0] s;
      unique case (bits)
         6'd1: s = 8'd255;
         6'd2: s = 8'd85;
         6'd3: s = 8'd36;
         6'd4: s = 8'd17;
         6'd5: s = 8'd8;
         6'd6: s = 8'd4;
         6'd7: s = 8'd2;
         6'd8: s = 8'd1;
         default: s = 8'd0;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/core/bitmap_pixel_decoder_blender_core.sv @@
// channel  direction  ports
// req      in         req_valid/req_stall, func, data byte, palette entry, background
// rsp      out        rsp_valid/rsp_stall, pixel rgb, column, display row, last flags
// csr      in         csr_write_enable, csr_index, csr_data
//
// each word sets off busy states by kind: palette depths a read state, then their pixels
// read and emitted in turn as the output slot frees; a gathering byte none; a completing
// 24-bit byte emit; a completing 16/32-bit byte the 32-step mask scan, mul, blend, emit
// req_stall stays high while busy; reset clears counters and the output valid flag
// palette is undefined until written
// rsp_stall holds the output word and the sequencer waits for the slot
module bitmap_pixel_decoder_blender_core #(
   parameter int MAX_WIDTH       = 4096,
   parameter int MAX_HEIGHT      = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [7:0]  req_palette_red,
   input  logic [7:0]  req_palette_green,
   input  logic [7:0]  req_palette_blue,
   input  logic [7:0]  req_back_red,
   input  logic [7:0]  req_back_green,
   input  logic [7:0]  req_back_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_red,
   output logic [7:0]  rsp_pixel_green,
   output logic [7:0]  rsp_pixel_blue,
   output logic [11:0] rsp_column,
   output logic [11:0] rsp_display_row,
   output logic        rsp_last_of_item,
   output logic        rsp_last_of_image,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int PAW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   // configuration
   logic [5:0]  bpp_ff;
   logic [12:0] width_ff, height_ff;
   logic [31:0] mask_ff [bpd_pkg::NUM_CH];

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= 6'd24;
         width_ff <= 13'd1;
         height_ff <= 13'd1;
         mask_ff[bpd_pkg::CH_RED] <= 32'h00FF0000;
         mask_ff[bpd_pkg::CH_GREEN] <= 32'h0000FF00;
         mask_ff[bpd_pkg::CH_BLUE] <= 32'h000000FF;
         mask_ff[bpd_pkg::CH_ALPHA] <= 32'h0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bpd_pkg::REG_BPP:        bpp_ff <= csr_data[5:0];
            bpd_pkg::REG_WIDTH:      width_ff <= csr_data[12:0];
            bpd_pkg::REG_HEIGHT:     height_ff <= csr_data[12:0];
            bpd_pkg::REG_MASK_RED:   mask_ff[bpd_pkg::CH_RED] <= csr_data;
            bpd_pkg::REG_MASK_GREEN: mask_ff[bpd_pkg::CH_GREEN] <= csr_data;
            bpd_pkg::REG_MASK_BLUE:  mask_ff[bpd_pkg::CH_BLUE] <= csr_data;
            bpd_pkg::REG_MASK_ALPHA: mask_ff[bpd_pkg::CH_ALPHA] <= csr_data;
            default: ;
         endcase
      end
   end

   bpd_pkg::state_type state_ff, state_in;

   logic [12:0] col_ff, col_in, row_ff, row_in;
   logic [1:0]  phase_ff, phase_in;
   logic        pad_ff, pad_in;
   logic [23:0] gather_ff, gather_in;
   logic [1:0]  bg_ff, bg_in;
   logic [7:0]  byte_ff;
   logic [2:0]  k_ff, k_in;
   logic [23:0] rgb_ff;
   logic [7:0]  back_ff [3];
   logic [31:0] msh_ff [bpd_pkg::NUM_CH];
   logic [31:0] val_ff [bpd_pkg::NUM_CH];
   logic        found_ff [bpd_pkg::NUM_CH];
   logic [5:0]  cnt_ff [bpd_pkg::NUM_CH];
   logic [7:0]  chan_ff [bpd_pkg::NUM_CH];
   logic [4:0]  step_ff;

   logic [23:0] pal_mem [PALETTE_ENTRIES];
   logic [23:0] rd_data_ff;
   logic        rd_ok_ff;

   logic        rsp_valid_ff;
   logic [23:0] rsp_rgb_ff;
   logic [11:0] rsp_col_ff, rsp_row_ff;
   logic        rsp_item_ff, rsp_image_ff;

   // limited image size
   logic [12:0] w_lim, h_lim;
   always_comb begin
      if (width_ff == 13'd0) w_lim = 13'd1;
      else if (32'(width_ff) > 32'(MAX_WIDTH)) w_lim = 13'(MAX_WIDTH);
      else w_lim = width_ff;
      if (height_ff == 13'd0) h_lim = 13'd1;
      else if (32'(height_ff) > 32'(MAX_HEIGHT)) h_lim = 13'(MAX_HEIGHT);
      else h_lim = height_ff;
   end

   logic end_row, end_img;
   logic [12:0] disp_row;
   assign end_row = ({1'b0, col_ff} + 14'd1) >= {1'b0, w_lim};
   assign end_img = end_row && (({1'b0, row_ff} + 14'd1) >= {1'b0, h_lim});
   assign disp_row = h_lim - 13'd1 - row_ff;

   // depth decode
   logic is_pal, is_dir;
   logic [2:0] need, npix_last;
   assign is_pal = (bpp_ff == 6'd1) || (bpp_ff == 6'd4) || (bpp_ff == 6'd8);
   assign is_dir = (bpp_ff == 6'd16) || (bpp_ff == 6'd24) || (bpp_ff == 6'd32);
   always_comb begin
      unique case (bpp_ff)
         6'd16: need = 3'd2;
         6'd24: need = 3'd3;
         default: need = 3'd4;
      endcase
      unique case (bpp_ff)
         6'd1: npix_last = 3'd7;
         6'd4: npix_last = 3'd1;
         default: npix_last = 3'd0;
      endcase
   end

   // word acceptance
   logic acc, data_ok, pad_use, start_pal, dir_byte, gather_more, dir_done;
   logic start_24, start_scan;
   assign acc         = req_valid && (state_ff == bpd_pkg::ST_IDLE);
   assign data_ok     = acc && (req_func == bpd_pkg::FUNC_DATA) && (is_pal || is_dir);
   assign pad_use     = data_ok && pad_ff;
   assign start_pal   = data_ok && !pad_ff && is_pal;
   assign dir_byte    = data_ok && !pad_ff && is_dir;
   assign gather_more = dir_byte && (({1'b0, bg_ff} + 3'd1) < need);
   assign dir_done    = dir_byte && !gather_more;
   assign start_24    = dir_done && (bpp_ff == 6'd24);
   assign start_scan  = dir_done && (bpp_ff != 6'd24);

   logic [31:0] word_acc;
   always_comb begin
      word_acc = {8'd0, gather_ff} | ({24'd0, req_data_byte} << {bg_ff, 3'b000});
      if (bpp_ff == 6'd16) word_acc = word_acc & 32'h0000FFFF;
   end

   // control
   logic slot_free, emit_go, rd_en, pal_last;
   logic [2:0] kk;
   logic [7:0] pal_idx;
   logic [23:0] emit_rgb;
   logic emit_last;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pal_last  = end_row || (k_ff == npix_last);

   always_comb begin
      unique case (state_ff)
         bpd_pkg::ST_IDLE: begin
            if (start_pal) state_in = bpd_pkg::ST_READ;
            else if (start_24) state_in = bpd_pkg::ST_EMIT;
            else if (start_scan) state_in = bpd_pkg::ST_SCAN;
            else state_in = bpd_pkg::ST_IDLE;
         end
         bpd_pkg::ST_READ:  state_in = bpd_pkg::ST_LOOK;
         bpd_pkg::ST_LOOK:  state_in = (emit_go && pal_last) ? bpd_pkg::ST_IDLE
                                                             : bpd_pkg::ST_LOOK;
         bpd_pkg::ST_SCAN:  state_in = (step_ff == 5'd31) ? bpd_pkg::ST_MUL
                                                          : bpd_pkg::ST_SCAN;
         bpd_pkg::ST_MUL:   state_in = bpd_pkg::ST_BLEND;
         bpd_pkg::ST_BLEND: state_in = bpd_pkg::ST_EMIT;
         bpd_pkg::ST_EMIT:  state_in = emit_go ? bpd_pkg::ST_IDLE : bpd_pkg::ST_EMIT;
         default:           state_in = bpd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != bpd_pkg::ST_IDLE);
      emit_go   = slot_free &&
                  ((state_ff == bpd_pkg::ST_LOOK) || (state_ff == bpd_pkg::ST_EMIT));
      rd_en     = (state_ff == bpd_pkg::ST_READ) ||
                  ((state_ff == bpd_pkg::ST_LOOK) && emit_go && !pal_last);
      emit_rgb  = (state_ff == bpd_pkg::ST_LOOK) ? (rd_ok_ff ? rd_data_ff : 24'd0) : rgb_ff;
      emit_last = (state_ff == bpd_pkg::ST_LOOK) ? pal_last : 1'b1;
   end

   // palette index of the pixel being read
   always_comb begin
      kk = (state_ff == bpd_pkg::ST_READ) ? k_ff : k_ff + 3'd1;
      unique case (bpp_ff)
         6'd1: pal_idx = {7'd0, byte_ff[3'd7 - kk]};
         6'd4: pal_idx = kk[0] ? {4'd0, byte_ff[3:0]} : {4'd0, byte_ff[7:4]};
         default: pal_idx = byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (acc && (req_func == bpd_pkg::FUNC_PALETTE) &&
          (32'(req_palette_index) < 32'(PALETTE_ENTRIES))) begin
         pal_mem[req_palette_index[PAW-1:0]] <=
            {req_palette_red, req_palette_green, req_palette_blue};
      end
      if (rd_en) begin
         rd_data_ff <= pal_mem[pal_idx[PAW-1:0]];
         rd_ok_ff <= 32'(pal_idx) < 32'(PALETTE_ENTRIES);
      end
   end

   // counters and gather
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      phase_in = phase_ff;
      pad_in = pad_ff;
      gather_in = gather_ff;
      bg_in = bg_ff;
      k_in = k_ff;
      if (acc && (req_func == bpd_pkg::FUNC_RESTART)) begin
         col_in = '0;
         row_in = '0;
         phase_in = '0;
         pad_in = 1'b0;
         gather_in = '0;
         bg_in = '0;
      end
      if (data_ok) phase_in = phase_ff + 2'd1;
      if (pad_use && (phase_in == 2'd0)) pad_in = 1'b0;
      if (start_pal) k_in = 3'd0;
      if (gather_more) begin
         gather_in = gather_ff | ({16'd0, req_data_byte} << {bg_ff, 3'b000});
         bg_in = bg_ff + 2'd1;
      end
      if (dir_done) begin
         gather_in = '0;
         bg_in = '0;
      end
      if (emit_go) begin
         k_in = k_ff + 3'd1;
         if (end_row) begin
            col_in = '0;
            row_in = end_img ? 13'd0 : row_ff + 13'd1;
            gather_in = '0;
            bg_in = '0;
            if (phase_ff != 2'd0) pad_in = 1'b1;
         end else begin
            col_in = col_ff + 13'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpd_pkg::ST_IDLE;
         col_ff <= '0;
         row_ff <= '0;
         phase_ff <= '0;
         pad_ff <= 1'b0;
         gather_ff <= '0;
         bg_ff <= '0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         row_ff <= row_in;
         phase_ff <= phase_in;
         pad_ff <= pad_in;
         gather_ff <= gather_in;
         bg_ff <= bg_in;
         k_ff <= k_in;
         if (emit_go) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_rgb_ff <= emit_rgb;
         rsp_col_ff <= col_ff[11:0];
         rsp_row_ff <= disp_row[11:0];
         rsp_item_ff <= emit_last;
         rsp_image_ff <= end_img;
      end
   end

   // channel datapath: mask scan, scale, blend
   logic [16:0] blend_sum [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         blend_sum[c] = 17'(back_ff[c] * (8'd255 - chan_ff[bpd_pkg::CH_ALPHA])) +
                        17'(chan_ff[c] * chan_ff[bpd_pkg::CH_ALPHA]);
      end
   end

   always_ff @(posedge clock) begin
      if (start_pal) byte_ff <= req_data_byte;
      if (start_24) rgb_ff <= {req_data_byte, gather_ff[15:0]};
      if (start_scan) begin
         back_ff[bpd_pkg::CH_RED] <= req_back_red;
         back_ff[bpd_pkg::CH_GREEN] <= req_back_green;
         back_ff[bpd_pkg::CH_BLUE] <= req_back_blue;
         step_ff <= '0;
         for (int c = 0; c < bpd_pkg::NUM_CH; c++) begin
            msh_ff[c] <= mask_ff[c];
            val_ff[c] <= word_acc & mask_ff[c];
            found_ff[c] <= 1'b0;
            cnt_ff[c] <= '0;
         end
      end
      if (state_ff == bpd_pkg::ST_SCAN) begin
         step_ff <= step_ff + 5'd1;
         // one mask bit a step: count set bits, drop value bits below the lowest one
         for (int c = 0; c < bpd_pkg::NUM_CH; c++) begin
            msh_ff[c] <= msh_ff[c] >> 1;
            if (msh_ff[c][0]) begin
               found_ff[c] <= 1'b1;
               cnt_ff[c] <= cnt_ff[c] + 6'd1;
            end else if (!found_ff[c]) begin
               val_ff[c] <= val_ff[c] >> 1;
            end
         end
      end
      if (state_ff == bpd_pkg::ST_MUL) begin
         for (int c = 0; c < bpd_pkg::NUM_CH; c++) begin
            chan_ff[c] <= 8'(val_ff[c][7:0] * bpd_pkg::scale_of(cnt_ff[c]));
         end
         // empty alpha mask means opaque
         if (cnt_ff[bpd_pkg::CH_ALPHA] == 6'd0) chan_ff[bpd_pkg::CH_ALPHA] <= 8'd255;
      end
      if (state_ff == bpd_pkg::ST_BLEND) begin
         rgb_ff <= {blend_sum[0][15:8], blend_sum[1][15:8], blend_sum[2][15:8]};
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_red     = rsp_rgb_ff[23:16];
   assign rsp_pixel_green   = rsp_rgb_ff[15:8];
   assign rsp_pixel_blue    = rsp_rgb_ff[7:0];
   assign rsp_column        = rsp_col_ff;
   assign rsp_display_row   = rsp_row_ff;
   assign rsp_last_of_item  = rsp_item_ff;
   assign rsp_last_of_image = rsp_image_ff;

endmodule

@@ rtl/core/bpd_checker.sv @@
module bpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_column,
   input logic        rsp_last_of_item,
   input logic        rsp_last_of_image
);

   // a word held under stall stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_column))
      else $error("rsp column changed under stall");

   // image end always closes the byte's pixel run
   a_image_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_image |-> rsp_last_of_item)
      else $error("image end without item end");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind bitmap_pixel_decoder_blender_core bpd_checker u_bpd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_column(rsp_column),
   .rsp_last_of_item(rsp_last_of_item),
   .rsp_last_of_image(rsp_last_of_image)
);
